// ----- src/mtg_pkg.sv -----
package mtg_pkg;

  localparam int unsigned StateWords  = 624;
  localparam int unsigned TwistOffset = 397;
  localparam int unsigned AddrW       = $clog2(StateWords);
  localparam int unsigned WordW       = 32;

  localparam logic [AddrW-1:0] LastAddr   = AddrW'(StateWords - 1);
  localparam logic [AddrW:0]   WrapLimit  = (AddrW + 1)'(StateWords);
  localparam logic [AddrW:0]   OffsetWide = (AddrW + 1)'(TwistOffset);

  localparam logic [WordW-1:0] SeedMult    = 32'd1812433253;
  localparam logic [WordW-1:0] TwistMatrix = 32'h9908_B0DF;
  localparam logic [WordW-1:0] TemperB     = 32'h9D2C_5680;
  localparam logic [WordW-1:0] TemperC     = 32'hEFC6_0000;

  localparam logic CmdSeed = 1'b0;
  localparam logic CmdNext = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StSeedMul,
    StSeedAdd,
    StRdNxt,
    StRdMid,
    StGenWr
  } mtg_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic seed_load;
    logic seed_mul;
    logic seed_add;
    logic rd_cur;
    logic rd_nxt;
    logic rd_mid;
    logic gen_wr;
    logic unseeded_res;
  } mtg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seed_last;
    logic seeded;
  } mtg_status_t;

  function automatic logic [WordW-1:0] twist(input logic [WordW-1:0] cur,
                                             input logic [WordW-1:0] nxt);
    logic [WordW-1:0] y;
    logic [WordW-1:0] r;
    y = {cur[WordW-1], nxt[WordW-2:0]};
    r = y >> 1;
    if (nxt[0]) begin
      r = r ^ TwistMatrix;
    end
    return r;
  endfunction

  function automatic logic [WordW-1:0] temper(input logic [WordW-1:0] w);
    logic [WordW-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ----- src/mersenne_twister_generator_unit.sv -----
// Next item: 3 RAM reads, then the write state, which also loads the result register and its strobe.
// Next items do not overlap: the state RAM has a single read port, and busy holds until the write.
// Next before any seed: result strobes in the cycle after acceptance, 1 item per cycle.
// Seed item: writes word 0, then 623 words, multiply then add each; busy until the last, no result.
// Reset clears position, seeded flag, controller and strobe; state RAM is not cleared.
// The receiver cannot stall: each result is presented for exactly one cycle.
module mersenne_twister_generator_unit
  import mtg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             command_i,
  input  logic [WordW-1:0] seed_value_i,
  output logic             result_valid_o,
  output logic [WordW-1:0] random_word_o,
  output logic             not_seeded_o
);

  // The controller sequences each item; the datapath holds the state RAM,
  // the read position, the seeding recurrence and the output register.
  // A next item reads word p at acceptance, then word p+1, then word p+397,
  // and in the write state writes the regenerated word back to p while its
  // tempered value is loaded into the result register. Seeding writes word 0
  // at acceptance and then, for each remaining word, runs a multiply state
  // and then a state for the add of the word index and the RAM write.

  mtg_cmd_t    cmd;
  mtg_status_t status;

  mtg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  mtg_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .seed_value_i   (seed_value_i),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .random_word_o  (random_word_o),
    .not_seeded_o   (not_seeded_o)
  );

  // An unseeded result always carries a zero word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && not_seeded_o) |-> (random_word_o == '0))
    else $error("unseeded result with nonzero word");

  // A next item before any seed answers in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CmdNext && !status.seeded)
      |=> (result_valid_o && not_seeded_o))
    else $error("missing unseeded result");

  // A seed item makes the block busy and yields no result as it starts seeding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CmdSeed) |=> (busy && !result_valid_o))
    else $error("seed item not sequenced");

  // A regular result only follows a generation write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !not_seeded_o) |-> $past(cmd.gen_wr))
    else $error("seeded result without generation step");

endmodule

// ----- src/mtg_ram.sv -----
module mtg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/mtg_datapath.sv -----
module mtg_datapath
  import mtg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mtg_cmd_t          cmd_i,
  input  logic [WordW-1:0]  seed_value_i,
  output mtg_status_t       status_o,
  output logic              result_valid_o,
  output logic [WordW-1:0]  random_word_o,
  output logic              not_seeded_o
);

  logic [AddrW-1:0] pos_q, pos_d;
  logic             seeded_q, seeded_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [WordW-1:0] prev_q, prev_d;
  logic [WordW-1:0] prod_q, prod_d;
  logic [WordW-1:0] cur_q, cur_d;
  logic [WordW-1:0] nxt_q, nxt_d;
  logic             valid_q, valid_d;
  logic [WordW-1:0] word_q, word_d;
  logic             ns_q, ns_d;

  logic [AddrW-1:0] pos_next;
  logic [AddrW-1:0] pos_mid;
  logic [AddrW:0]   mid_sum;
  logic [WordW-1:0] seed_word;
  logic [WordW-1:0] gen_word;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [WordW-1:0] ram_rdata;

  assign pos_next = (pos_q == LastAddr) ? '0 : pos_q + 1'b1;
  assign mid_sum  = {1'b0, pos_q} + OffsetWide;
  assign pos_mid  = (mid_sum >= WrapLimit) ? AddrW'(mid_sum - WrapLimit) : mid_sum[AddrW-1:0];

  assign seed_word = prod_q + {{(WordW - AddrW){1'b0}}, idx_q};
  assign gen_word  = ram_rdata ^ twist(cur_q, nxt_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = gen_word;
    if (cmd_i.seed_load) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = seed_value_i;
    end else if (cmd_i.seed_add) begin
      ram_we    = 1'b1;
      ram_waddr = idx_q;
      ram_wdata = seed_word;
    end else if (cmd_i.gen_wr) begin
      ram_we    = 1'b1;
    end
  end

  always_comb begin
    priority if (cmd_i.rd_nxt) begin
      ram_raddr = pos_next;
    end else if (cmd_i.rd_mid) begin
      ram_raddr = pos_mid;
    end else begin
      ram_raddr = pos_q;
    end
  end

  mtg_ram #(
    .Width (WordW),
    .Depth (StateWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    pos_d    = pos_q;
    seeded_d = seeded_q;
    idx_d    = idx_q;
    prev_d   = prev_q;
    prod_d   = prod_q;
    cur_d    = cur_q;
    nxt_d    = nxt_q;
    valid_d  = 1'b0;
    word_d   = word_q;
    ns_d     = ns_q;
    if (cmd_i.seed_load) begin
      pos_d    = '0;
      seeded_d = 1'b1;
      idx_d    = AddrW'(1);
      prev_d   = seed_value_i;
    end
    if (cmd_i.seed_mul) begin
      prod_d = SeedMult * (prev_q ^ (prev_q >> 30));
    end
    if (cmd_i.seed_add) begin
      prev_d = seed_word;
      idx_d  = idx_q + 1'b1;
    end
    if (cmd_i.rd_nxt) begin
      cur_d = ram_rdata;
    end
    if (cmd_i.rd_mid) begin
      nxt_d = ram_rdata;
    end
    if (cmd_i.gen_wr) begin
      pos_d   = pos_next;
      valid_d = 1'b1;
      word_d  = temper(gen_word);
      ns_d    = 1'b0;
    end
    if (cmd_i.unseeded_res) begin
      valid_d = 1'b1;
      word_d  = '0;
      ns_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      seeded_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      seeded_q <= seeded_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    prev_q <= prev_d;
    prod_q <= prod_d;
    cur_q  <= cur_d;
    nxt_q  <= nxt_d;
    word_q <= word_d;
    ns_q   <= ns_d;
  end

  assign status_o.seed_last = (idx_q == LastAddr);
  assign status_o.seeded    = seeded_q;

  assign result_valid_o = valid_q;
  assign random_word_o  = word_q;
  assign not_seeded_o   = ns_q;

endmodule

// ----- src/mtg_ctrl.sv -----
module mtg_ctrl
  import mtg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        command_i,
  input  mtg_status_t status_i,
  output mtg_cmd_t    cmd_o,
  output logic        busy_o
);

  mtg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          if (command_i == CmdSeed) begin
            cmd_o.seed_load = 1'b1;
            state_d         = StSeedMul;
          end else if (status_i.seeded) begin
            cmd_o.rd_cur = 1'b1;
            state_d      = StRdNxt;
          end else begin
            cmd_o.unseeded_res = 1'b1;
          end
        end
      end
      StSeedMul: begin
        cmd_o.seed_mul = 1'b1;
        state_d        = StSeedAdd;
      end
      StSeedAdd: begin
        cmd_o.seed_add = 1'b1;
        state_d        = status_i.seed_last ? StIdle : StSeedMul;
      end
      StRdNxt: begin
        cmd_o.rd_nxt = 1'b1;
        state_d      = StRdMid;
      end
      StRdMid: begin
        cmd_o.rd_mid = 1'b1;
        state_d      = StGenWr;
      end
      StGenWr: begin
        cmd_o.gen_wr = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy_o = (state_q != StIdle);

endmodule
